// ----- rtl/pmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_pkg
// Shared types, register codes and constant functions of the polynomial
// mutation gene block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmg_pkg;

   localparam int GENE_W      = 32;
   localparam int DRAW_W      = 16;
   localparam int PROB_W      = 17;
   localparam int ETA_W       = 16;
   localparam int CSR_W       = 32;
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_LOWER = 2'd0,
      CSR_UPPER = 2'd1,
      CSR_PROB  = 2'd2,
      CSR_ETA   = 2'd3
   } csr_index_type;

   localparam logic signed [GENE_W-1:0] LOWER_RESET = -32'sd6553600;
   localparam logic signed [GENE_W-1:0] UPPER_RESET = 32'sd6553600;
   localparam logic [PROB_W-1:0]        PROB_RESET  = 17'd6554;
   localparam logic [ETA_W-1:0]         ETA_RESET   = 16'd5120;

   // half point of a draw, full scale of a draw, 1.0 in Q8.8
   localparam logic [DRAW_W-1:0] HALF_DRAW = 16'd32768;
   localparam logic [PROB_W-1:0] FULL_DRAW = 17'd65536;
   localparam logic [PROB_W-1:0] ETA_ONE   = 17'd256;

   // one classified gene as it travels from front to back
   typedef struct packed {
      logic                     byp;       // result already known
      logic                     changed;
      logic                     up;        // move toward the upper bound
      logic signed [GENE_W-1:0] res;       // bypass value, or clamped gene
      logic [DRAW_W-1:0]        shape;
      logic [GENE_W-1:0]        bound_gap; // distance to the bound opposite the move
      logic [GENE_W-1:0]        span;      // upper - lower
   } item_type;

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bit_v;
      res   = '0;
      rem   = v;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-idx) in Q.frac_bits, by repeated square roots from 0.5
   function automatic logic [63:0] root_const(input int frac_bits, input int idx);
      logic [63:0] c;
      c = 64'(1) << (frac_bits - 1);
      for (int i = 1; i <= idx; i++) begin
         c = isqrt64(c << frac_bits);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pmg_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_ifs
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmg_req_if import pmg_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [GENE_W-1:0] gene_value;
   logic [DRAW_W-1:0]        select_draw;
   logic [DRAW_W-1:0]        shape_draw;

   modport source (output valid, gene_value, select_draw, shape_draw, input ready);
   modport sink   (input valid, gene_value, select_draw, shape_draw, output ready);
endinterface

interface pmg_rsp_if import pmg_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [GENE_W-1:0] new_gene;
   logic                     gene_changed;

   modport source (output valid, new_gene, gene_changed, input ready);
   modport sink   (input valid, new_gene, gene_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/pmg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_front
// Accepts genes, decides on mutation, clamps and measures the distance to
// the bound opposite the direction of the move.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_front import pmg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pmg_req_if.sink                  req,
   input  logic signed [GENE_W-1:0] lower,
   input  logic signed [GENE_W-1:0] upper,
   input  logic [PROB_W-1:0]        prob,
   output logic                     out_valid,
   input  logic                     out_ready,
   output item_type                 out_item
);

   logic                     vld_ff, vld_in;
   item_type                 item_ff, item_in;
   logic                     sel, empty, up;
   logic signed [GENE_W-1:0] yc0, yc;
   logic [GENE_W:0]          dist_w, span_w;

   assign req.ready = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_item  = item_ff;

   // classify the incoming transaction
   always_comb begin
      sel    = {1'b0, req.select_draw} <= prob;
      empty  = upper <= lower;
      up     = req.shape_draw > HALF_DRAW;
      yc0    = (req.gene_value < lower) ? lower : req.gene_value;
      yc     = (yc0 > upper) ? upper : yc0;
      span_w = {upper[GENE_W-1], upper} - {lower[GENE_W-1], lower};
      dist_w = up ? ({yc[GENE_W-1], yc} - {lower[GENE_W-1], lower})
                  : ({upper[GENE_W-1], upper} - {yc[GENE_W-1], yc});
      item_in.byp       = !sel || empty;
      item_in.changed   = sel;
      item_in.up        = up;
      item_in.res       = sel ? yc : req.gene_value;
      item_in.shape     = req.shape_draw;
      item_in.bound_gap = dist_w[GENE_W-1:0];
      item_in.span      = span_w[GENE_W-1:0];
      vld_in            = req.ready ? req.valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pmg_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_fifo import pmg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pmg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_div #(
   parameter int DVS_W = 32,
   parameter int Q_W   = 25,
   parameter int PW    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DVS_W-1:0] rem_init,
   input  logic [Q_W-1:0]   low_bits,
   input  logic [DVS_W-1:0] divisor,
   input  logic [PW-1:0]    in_pay,
   output logic             out_valid,
   output logic [Q_W-1:0]   quot,
   output logic [PW-1:0]    out_pay
);

   logic             vld_ff  [Q_W];
   logic [DVS_W-1:0] rem_ff  [Q_W];
   logic [Q_W-1:0]   quot_ff [Q_W];
   logic [Q_W-1:0]   low_ff  [Q_W];
   logic [DVS_W-1:0] dvs_ff  [Q_W];
   logic [PW-1:0]    pay_ff  [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_step
      logic             v_cur;
      logic [DVS_W-1:0] r_cur, d_cur;
      logic [Q_W-1:0]   q_cur, lo_cur;
      logic [PW-1:0]    p_cur;
      logic [DVS_W:0]   trial, diff;
      logic             ge;

      if (j == 0) begin : g_first
         assign v_cur  = in_valid;
         assign r_cur  = rem_init;
         assign d_cur  = divisor;
         assign q_cur  = '0;
         assign lo_cur = low_bits;
         assign p_cur  = in_pay;
      end else begin : g_next
         assign v_cur  = vld_ff[j-1];
         assign r_cur  = rem_ff[j-1];
         assign d_cur  = dvs_ff[j-1];
         assign q_cur  = quot_ff[j-1];
         assign lo_cur = low_ff[j-1];
         assign p_cur  = pay_ff[j-1];
      end

      // shift in the next dividend bit, trial subtract
      assign trial = {r_cur, lo_cur[Q_W-1-j]};
      assign diff  = trial - {1'b0, d_cur};
      assign ge    = trial >= {1'b0, d_cur};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quot_ff[j] <= {q_cur[Q_W-2:0], ge};
            low_ff[j]  <= lo_cur;
            dvs_ff[j]  <= d_cur;
            pay_ff[j]  <= p_cur;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign quot      = quot_ff[Q_W-1];
   assign out_pay   = pay_ff[Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/pmg_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_log
// Pipelined -log2(x) for x in (0, 1]: normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_log #(
   parameter int F  = 24,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [F:0]    x,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [F+5:0]  nlog,
   output logic          zero,
   output logic [PW-1:0] out_pay
);

   localparam int KW = $clog2(F + 1);
   localparam int LW = F + 6;

   logic [KW-1:0] k;

   // stage a: leading one position
   logic          v_a_ff, z_a_ff;
   logic [F:0]    x_a_ff;
   logic [KW-1:0] sh_a_ff;
   logic [PW-1:0] p_a_ff;

   // stage b: normalized mantissa
   logic          v_b_ff, z_b_ff;
   logic [F:0]    m_b_ff;
   logic [KW-1:0] sh_b_ff;
   logic [PW-1:0] p_b_ff;

   // squaring stages
   logic          vld_ff  [F];
   logic          zr_ff   [F];
   logic [F:0]    m_ff    [F];
   logic [F-1:0]  frac_ff [F];
   logic [KW-1:0] sh_ff   [F];
   logic [PW-1:0] pay_ff  [F];

   // output stage
   logic          v_o_ff, z_o_ff;
   logic [LW-1:0] nlog_ff;
   logic [PW-1:0] p_o_ff;

   always_comb begin
      k = '0;
      for (int i = 0; i <= F; i++) begin
         if (x[i]) begin
            k = KW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_o_ff <= 1'b0;
      end else if (en) begin
         v_a_ff <= in_valid;
         v_b_ff <= v_a_ff;
         v_o_ff <= vld_ff[F-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_a_ff  <= x;
         sh_a_ff <= KW'(F) - k;
         z_a_ff  <= x == '0;
         p_a_ff  <= in_pay;
         m_b_ff  <= x_a_ff << sh_a_ff;
         sh_b_ff <= sh_a_ff;
         z_b_ff  <= z_a_ff;
         p_b_ff  <= p_a_ff;
      end
   end

   for (genvar j = 0; j < F; j++) begin : g_sq
      logic          v_cur, z_cur;
      logic [F:0]    m_cur;
      logic [F-1:0]  f_cur;
      logic [KW-1:0] s_cur;
      logic [PW-1:0] p_cur;
      logic [2*F+1:0] sq;
      logic [F+1:0]  sqs;

      if (j == 0) begin : g_first
         assign v_cur = v_b_ff;
         assign z_cur = z_b_ff;
         assign m_cur = m_b_ff;
         assign f_cur = '0;
         assign s_cur = sh_b_ff;
         assign p_cur = p_b_ff;
      end else begin : g_next
         assign v_cur = vld_ff[j-1];
         assign z_cur = zr_ff[j-1];
         assign m_cur = m_ff[j-1];
         assign f_cur = frac_ff[j-1];
         assign s_cur = sh_ff[j-1];
         assign p_cur = pay_ff[j-1];
      end

      // square, renormalize when at or above two
      assign sq  = m_cur * m_cur;
      assign sqs = sq[2*F+1:F];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j]    <= sqs[F+1] ? sqs[F+1:1] : sqs[F:0];
            frac_ff[j] <= {f_cur[F-2:0], sqs[F+1]};
            zr_ff[j]   <= z_cur;
            sh_ff[j]   <= s_cur;
            pay_ff[j]  <= p_cur;
         end
      end
   end

   // integer part minus fraction
   always_ff @(posedge clock) begin
      if (en) begin
         nlog_ff <= (LW'(sh_ff[F-1]) << F) - LW'(frac_ff[F-1]);
         z_o_ff  <= zr_ff[F-1];
         p_o_ff  <= pay_ff[F-1];
      end
   end

   assign out_valid = v_o_ff;
   assign nlog      = nlog_ff;
   assign zero      = z_o_ff;
   assign out_pay   = p_o_ff;

endmodule

`default_nettype wire

// ----- rtl/pmg_exp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_exp
// Pipelined 2^(-e): one fraction bit per stage against a root constant,
// then the integer part as a right shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_exp import pmg_pkg::*; #(
   parameter int F  = 24,
   parameter int EW = 39,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [EW-1:0] e,
   input  logic          kill,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [F:0]    result,
   output logic [PW-1:0] out_pay
);

   localparam int KW = $clog2(F + 1);
   localparam int NW = EW - F;

   logic [NW-1:0] n_in;
   logic          big_in;

   logic          vld_ff [F];
   logic [F:0]    r_ff   [F];
   logic [F-1:0]  f_ff   [F];
   logic [KW-1:0] sh_ff  [F];
   logic          big_ff [F];
   logic [PW-1:0] pay_ff [F];

   logic          v_o_ff;
   logic [F:0]    res_ff;
   logic [PW-1:0] p_o_ff;

   // results of a zero base or a shift past all bits are zero
   assign n_in   = e[EW-1:F];
   assign big_in = kill || (n_in > NW'(F));

   for (genvar j = 0; j < F; j++) begin : g_mul
      localparam logic [63:0] CW = root_const(F, j + 1);

      logic          v_cur, b_cur;
      logic [F:0]    r_cur, ci;
      logic [F-1:0]  f_cur;
      logic [KW-1:0] s_cur;
      logic [PW-1:0] p_cur;
      logic [2*F+1:0] prod;

      if (j == 0) begin : g_first
         assign v_cur = in_valid;
         assign b_cur = big_in;
         assign r_cur = {1'b1, {F{1'b0}}};
         assign f_cur = e[F-1:0];
         assign s_cur = n_in[KW-1:0];
         assign p_cur = in_pay;
      end else begin : g_next
         assign v_cur = vld_ff[j-1];
         assign b_cur = big_ff[j-1];
         assign r_cur = r_ff[j-1];
         assign f_cur = f_ff[j-1];
         assign s_cur = sh_ff[j-1];
         assign p_cur = pay_ff[j-1];
      end

      assign ci   = CW[F:0];
      assign prod = r_cur * ci;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]   <= f_cur[F-1-j] ? prod[2*F:F] : r_cur;
            f_ff[j]   <= f_cur;
            sh_ff[j]  <= s_cur;
            big_ff[j] <= b_cur;
            pay_ff[j] <= p_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_o_ff <= 1'b0;
      end else if (en) begin
         v_o_ff <= vld_ff[F-1];
      end
   end

   // integer part of the exponent
   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= big_ff[F-1] ? '0 : (r_ff[F-1] >> sh_ff[F-1]);
         p_o_ff <= pay_ff[F-1];
      end
   end

   assign out_valid = v_o_ff;
   assign result    = res_ff;
   assign out_pay   = p_o_ff;

endmodule

`default_nettype wire

// ----- rtl/pmg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_back
// Mutation datapath: distance ratio, two powers through log2/exp2, step
// scaling and final clamp, with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_back import pmg_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_type                 in_item,
   input  logic signed [GENE_W-1:0] lower,
   input  logic signed [GENE_W-1:0] upper,
   input  logic [ETA_W-1:0]         eta,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [GENE_W-1:0] new_gene,
   output logic                     gene_changed
);

   localparam int F  = FRAC_BITS;
   localparam int LW = F + 6;
   localparam int EW = LW + 9;
   localparam int IW = $bits(item_type);

   logic                 en;
   logic [PROB_W-1:0]    p;

   logic                 v1;
   logic [F:0]           xy;
   logic [IW-1:0]        pay1;

   logic                 v2, z2;
   logic [LW-1:0]        l2;
   logic [IW-1:0]        pay2;

   logic                 v3_ff, z3_ff;
   logic [EW-1:0]        e3_ff;
   logic [IW-1:0]        pay3_ff;
   logic [LW+PROB_W-1:0] pow_prod;

   logic                 v4;
   logic [F:0]           pw;
   logic [IW-1:0]        pay4;
   item_type             it4;

   logic                 v5_ff;
   logic [F:0]           val_ff;
   logic [IW-1:0]        pay5_ff;
   logic [DRAW_W-1:0]    coef_a, coef_b;
   logic [F:0]           coef_a_q, coef_b_q;
   logic [2*F+1:0]       mix_prod;
   logic [F+1:0]         mix_sum;

   logic                 v6, z6;
   logic [LW-1:0]        l6;
   logic [IW-1:0]        pay6;

   logic                 v7;
   logic [LW-1:0]        e7;
   logic [IW:0]          pay7;

   logic                 v8;
   logic [F:0]           root;
   logic [IW-1:0]        pay8;
   item_type             it8;

   logic                 v9_ff;
   logic [GENE_W-1:0]    step_ff;
   logic [IW-1:0]        pay9_ff;
   logic [F:0]           m8;
   logic [F+GENE_W:0]    step_prod;

   item_type             it9;
   logic signed [GENE_W+1:0] yc_x, lo_x, hi_x, sum_x, cl0_x, cl_x;

   logic                     out_vld_ff;
   logic signed [GENE_W-1:0] gene_ff, gene_in;
   logic                     chg_ff;

   // whole pipeline moves unless the output register is held
   assign en        = !out_vld_ff || out_ready;
   assign in_ready  = en;
   assign p         = {1'b0, eta} + ETA_ONE;

   // distance ratio to the bound
   pmg_div #(.DVS_W(GENE_W), .Q_W(F + 1), .PW(IW)) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .rem_init  ({1'b0, in_item.bound_gap[GENE_W-1:1]}),
      .low_bits  ({in_item.bound_gap[0], {F{1'b0}}}),
      .divisor   (in_item.span),
      .in_pay    (in_item),
      .out_valid (v1),
      .quot      (xy),
      .out_pay   (pay1)
   );

   pmg_log #(.F(F), .PW(IW)) u_log_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1),
      .x         (xy),
      .in_pay    (pay1),
      .out_valid (v2),
      .nlog      (l2),
      .zero      (z2),
      .out_pay   (pay2)
   );

   // exponent of the first power: log times eta+1
   assign pow_prod = l2 * p;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v5_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2;
         v5_ff <= v4;
         v9_ff <= v8;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e3_ff   <= pow_prod[LW+PROB_W-1:8];
         z3_ff   <= z2;
         pay3_ff <= pay2;
      end
   end

   pmg_exp #(.F(F), .EW(EW), .PW(IW)) u_exp_pow (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .e         (e3_ff),
      .kill      (z3_ff),
      .in_pay    (pay3_ff),
      .out_valid (v4),
      .result    (pw),
      .out_pay   (pay4)
   );

   // mix the power with the shape draw
   always_comb begin
      it4 = item_type'(pay4);
      if (it4.up) begin
         coef_a = 16'(FULL_DRAW - {1'b0, it4.shape});
         coef_b = it4.shape - HALF_DRAW;
      end else begin
         coef_a = it4.shape;
         coef_b = HALF_DRAW - it4.shape;
      end
      coef_a_q = {coef_a, {(F - 15){1'b0}}};
      coef_b_q = {coef_b, {(F - 15){1'b0}}};
      mix_prod = coef_b_q * pw;
      mix_sum  = {1'b0, coef_a_q} + mix_prod[2*F+1:F];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff  <= mix_sum[F:0];
         pay5_ff <= pay4;
      end
   end

   pmg_log #(.F(F), .PW(IW)) u_log_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .x         (val_ff),
      .in_pay    (pay5_ff),
      .out_valid (v6),
      .nlog      (l6),
      .zero      (z6),
      .out_pay   (pay6)
   );

   // exponent of the root: log divided by eta+1
   pmg_div #(.DVS_W(PROB_W), .Q_W(LW), .PW(IW + 1)) u_div_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6),
      .rem_init  ({{(PROB_W - 8){1'b0}}, l6[LW-1:LW-8]}),
      .low_bits  ({l6[LW-9:0], 8'b0}),
      .divisor   (p),
      .in_pay    ({z6, pay6}),
      .out_valid (v7),
      .quot      (e7),
      .out_pay   (pay7)
   );

   pmg_exp #(.F(F), .EW(LW), .PW(IW)) u_exp_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7),
      .e         (e7),
      .kill      (pay7[IW]),
      .in_pay    (pay7[IW-1:0]),
      .out_valid (v8),
      .result    (root),
      .out_pay   (pay8)
   );

   // step size: (1 - root) times the range
   always_comb begin
      it8       = item_type'(pay8);
      m8        = {1'b1, {F{1'b0}}} - root;
      step_prod = m8 * it8.span;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_prod[F+GENE_W-1:F];
         pay9_ff <= pay8;
      end
   end

   // apply the step and clamp, or take the bypass value
   always_comb begin
      it9   = item_type'(pay9_ff);
      yc_x  = {{2{it9.res[GENE_W-1]}}, it9.res};
      lo_x  = {{2{lower[GENE_W-1]}}, lower};
      hi_x  = {{2{upper[GENE_W-1]}}, upper};
      sum_x = it9.up ? yc_x + {2'b00, step_ff} : yc_x - {2'b00, step_ff};
      cl0_x = (sum_x < lo_x) ? lo_x : sum_x;
      cl_x  = (cl0_x > hi_x) ? hi_x : cl0_x;
      gene_in = it9.byp ? it9.res : cl_x[GENE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gene_ff <= gene_in;
         chg_ff  <= it9.changed;
      end
   end

   assign out_valid    = out_vld_ff;
   assign new_gene     = gene_ff;
   assign gene_changed = chg_ff;

endmodule

`default_nettype wire

// ----- rtl/polynomial_mutation_gene_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_mutation_gene_top
// Polynomial mutation of one gene per transaction, with bound, probability and distribution index registers.
// ----------------------------------------------------------------------------
// datapath: the two squaring chains of the log units, the two root-constant
//   chains of the exp units and the two bit-per-stage dividers
// throughput: one transaction per cycle; the whole back pipeline holds only
//   while the result register waits on rsp ready
// reset: synchronous, clears all valid flags and the queue and loads the
//   default bounds, probability and distribution index
`default_nettype none

module polynomial_mutation_gene_top import pmg_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   pmg_req_if.sink          req_bus,
   pmg_rsp_if.source        rsp_bus,
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic signed [GENE_W-1:0] lower_ff, upper_ff;
   logic [PROB_W-1:0]        prob_ff;
   logic [ETA_W-1:0]         eta_ff;

   logic     fr_valid, fr_ready;
   item_type fr_item;
   logic     q_valid, q_ready;
   item_type q_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOWER_RESET;
         upper_ff <= UPPER_RESET;
         prob_ff  <= PROB_RESET;
         eta_ff   <= ETA_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_LOWER: lower_ff <= csr_wdata;
            CSR_UPPER: upper_ff <= csr_wdata;
            CSR_PROB:  prob_ff  <= csr_wdata[PROB_W-1:0];
            CSR_ETA:   eta_ff   <= csr_wdata[ETA_W-1:0];
            default:   ;
         endcase
      end
   end

   pmg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .lower     (lower_ff),
      .upper     (upper_ff),
      .prob      (prob_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   pmg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   pmg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_item      (q_item),
      .lower        (lower_ff),
      .upper        (upper_ff),
      .eta          (eta_ff),
      .out_valid    (rsp_bus.valid),
      .out_ready    (rsp_bus.ready),
      .new_gene     (rsp_bus.new_gene),
      .gene_changed (rsp_bus.gene_changed)
   );

endmodule

`default_nettype wire

// ----- rtl/pmg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmg_checker
// Port-level checks of the mutation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pmg_checker import pmg_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [GENE_W-1:0] new_gene,
   input logic                     gene_changed
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_gene) && $stable(gene_changed))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_rst_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset leaves the front open
   a_rst_req: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready after reset");

   // the front refuses only after an offered transaction, a refusal or a reset
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(req_valid) || $past(!req_ready) || $past(reset))
      else $error("front closed without a transaction");

endmodule

bind polynomial_mutation_gene_top pmg_checker u_pmg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .new_gene     (rsp_bus.new_gene),
   .gene_changed (rsp_bus.gene_changed)
);

`default_nettype wire
